// ===== rtl/cdq_pkg.sv =====
// Shared constants, operation codes and control types for the circular deque.
package cdq_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int OPCODE_WIDTH    = 3;
   localparam int PUSH_WIDTH      = 32;
   localparam int OUT_VALUE_WIDTH = 32;
   localparam int OUT_COUNT_WIDTH = 5;

   localparam int REQ_DATA_WIDTH = PUSH_WIDTH;
   localparam int REQ_USER_WIDTH = OPCODE_WIDTH;
   localparam int RSP_DATA_WIDTH = 2 * OUT_VALUE_WIDTH + OUT_COUNT_WIDTH + 3;

   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_PEEK       = 3'd4;

   typedef struct packed {
      logic exec;
      logic read;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/cdq_ctrl.sv =====
// Controller state machine sequencing execute, slot read and result load.
module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  cdq_pkg::sts_type sts,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/cdq_datapath.sv =====
// Datapath: head and count registers, slot memory and the result register.
module cdq_datapath #(
   parameter int CAPACITY    = cdq_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = cdq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cdq_pkg::cmd_type                   cmd,
   output cdq_pkg::sts_type                   sts,
   input  logic [cdq_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [cdq_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cdq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import cdq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = IW + 1;

   logic [VALUE_WIDTH-1:0] slot_mem [CAPACITY];

   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rej_ff, rej_in;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [VALUE_WIDTH-1:0] wr_value;
   logic          full;
   logic          empty;

   logic [VALUE_WIDTH-1:0] front_rd_ff, back_rd_ff;
   logic [IW-1:0]          back_addr;

   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata_in;
   logic [OUT_VALUE_WIDTH-1:0] front_out, back_out;

   assign full     = (count_ff >= CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign wr_value = VALUE_WIDTH'(req_tdata);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rej_in   = rej_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff + count_ff[IW-1:0];
      if (cmd.exec) begin
         rej_in = 1'b0;
         unique case (req_tuser)
            OP_PUSH_BACK: begin
               if (full) begin
                  rej_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  rej_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_ff - IW'(1);
                  head_in  = head_ff - IW'(1);
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  rej_in = 1'b1;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rej_in = 1'b1;
               end else begin
                  count_in = count_ff - CW'(1);
                  head_in  = head_ff + IW'(1);
               end
            end
            default: begin
               rej_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rej_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rej_ff   <= rej_in;
      end
   end

   assign back_addr = head_ff + count_ff[IW-1:0] - IW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_value;
      end
      if (cmd.read) begin
         front_rd_ff <= slot_mem[head_ff];
         back_rd_ff  <= slot_mem[back_addr];
      end
   end

   assign front_out = empty ? '0 : OUT_VALUE_WIDTH'(front_rd_ff);
   assign back_out  = empty ? '0 : OUT_VALUE_WIDTH'(back_rd_ff);
   assign rsp_tdata_in = {rej_ff, full, empty, OUT_COUNT_WIDTH'(count_ff), back_out, front_out};

   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/circular_deque_top.sv =====
// Top level of the circular-buffer double-ended queue.
//
// Each transfer on the req channel is one operation: push back, push front,
// pop back, pop front or peek, selected by req_tuser; req_tdata carries the
// value for a push. Every operation yields exactly one rsp transfer with the
// front and back values, the entry count, empty and full flags and a reject
// flag for a push while full or a pop while empty.
// After the req transfer the controller steps through the read and load
// states and takes no new operation until the load: the push is written
// in the accept cycle, both ends are read through the registered read ports
// in the next, and the result is loaded once the output register is free.
// Reset empties the deque (head and count cleared); slot contents are left
// as they are, with no clearing pass. While rsp_tready is low the result
// holds in the output register; one further operation is still taken and
// its result waits inside until the output register frees.
module circular_deque_top #(
   parameter int CAPACITY    = cdq_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = cdq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // push_value
   input  logic [cdq_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // opcode
   input  logic [cdq_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // front_value, back_value, entry_count, is_empty, is_full, op_rejected
   output logic [cdq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import cdq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cdq_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/cdq_checker.sv =====
// Port-level checker for the circular deque, bound to the top level.
module cdq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [cdq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import cdq_pkg::*;

   localparam int CNT_LO   = 2 * OUT_VALUE_WIDTH;
   localparam int EMPTY_AT = CNT_LO + OUT_COUNT_WIDTH;
   localparam int FULL_AT  = EMPTY_AT + 1;

   logic empty_flag;
   logic full_flag;

   assign empty_flag = rsp_tdata[EMPTY_AT];
   assign full_flag  = rsp_tdata[FULL_AT];

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   else $error("stalled result changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && empty_flag |->
         rsp_tdata[CNT_LO-1:0] == '0 && rsp_tdata[EMPTY_AT-1:CNT_LO] == '0 && !full_flag)
   else $error("empty result with nonzero values or count");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
   else $error("operation taken while previous one in flight");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
   else $error("result valid after reset");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);

// ===== sim/deque_checker.sv =====
// Checker for the circular deque: predicts every result and compares each rsp transfer.
module deque_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [cdq_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [cdq_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [cdq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output int                                 mismatch_count,
   output int                                 pending
);
   import cdq_pkg::*;

   localparam int DEPTH     = CAPACITY_DEFAULT;
   localparam int IDX_WIDTH = $clog2(DEPTH);

   typedef struct packed {
      logic                       op_rejected;
      logic                       is_full;
      logic                       is_empty;
      logic [OUT_COUNT_WIDTH-1:0] entry_count;
      logic [OUT_VALUE_WIDTH-1:0] back_value;
      logic [OUT_VALUE_WIDTH-1:0] front_value;
   } deque_view_type;

   logic [OUT_VALUE_WIDTH-1:0] model_slots [DEPTH];
   logic [IDX_WIDTH-1:0]       model_head;
   logic [OUT_COUNT_WIDTH-1:0] model_count;
   deque_view_type             expected_views [$];
   int                         rsp_index;

   function automatic deque_view_type apply_op(input logic [OPCODE_WIDTH-1:0] op,
                                               input logic [PUSH_WIDTH-1:0] value);
      deque_view_type       view;
      logic [IDX_WIDTH-1:0] idx;
      view = '0;
      case (op)
         OP_PUSH_BACK: begin
            if (model_count == DEPTH) begin
               view.op_rejected = 1'b1;
            end else begin
               idx = model_head + model_count[IDX_WIDTH-1:0];
               model_slots[idx] = value;
               model_count = model_count + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (model_count == DEPTH) begin
               view.op_rejected = 1'b1;
            end else begin
               model_head = model_head - 1'b1;
               model_slots[model_head] = value;
               model_count = model_count + 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (model_count == 0) view.op_rejected = 1'b1;
            else model_count = model_count - 1'b1;
         end
         OP_POP_FRONT: begin
            if (model_count == 0) begin
               view.op_rejected = 1'b1;
            end else begin
               model_count = model_count - 1'b1;
               model_head = model_head + 1'b1;
            end
         end
         default: ;
      endcase
      if (model_count != 0) begin
         idx = model_head + model_count[IDX_WIDTH-1:0] - 1'b1;
         view.front_value = model_slots[model_head];
         view.back_value  = model_slots[idx];
      end
      view.entry_count = model_count;
      view.is_empty    = (model_count == 0);
      view.is_full     = (model_count == DEPTH);
      return view;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h want %h", rsp_index, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      deque_view_type got;
      deque_view_type want;
      if (reset) begin
         model_head  = '0;
         model_count = '0;
         expected_views.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_views.insert(expected_views.size(), apply_op(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected transfer", got.front_value, '0);
            end else begin
               want = expected_views[0];
               expected_views.delete(0);
               if (got.front_value !== want.front_value)
                  report_mismatch("front_value", got.front_value, want.front_value);
               if (got.back_value !== want.back_value)
                  report_mismatch("back_value", got.back_value, want.back_value);
               if (got.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(got.entry_count),
                                  32'(want.entry_count));
               if (got.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
               if (got.is_full !== want.is_full)
                  report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
               if (got.op_rejected !== want.op_rejected)
                  report_mismatch("op_rejected", 32'(got.op_rejected),
                                  32'(want.op_rejected));
            end
            rsp_index++;
         end
      end
      pending = expected_views.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the circular deque: clock, reset, operation stimulus and verdict.
module tb_top;
   import cdq_pkg::*;

   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_C = 3'd7;
   localparam int RANDOM_OPS  = 800;
   localparam int PHASE_OPS   = 100;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 400;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic [REQ_USER_WIDTH-1:0] req_tuser  = OP_PEEK;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   int                        mismatch_count;
   int                        pending;
   bit                        sender_idles = 1'b1;

   always #10 clock = ~clock;

   circular_deque_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   deque_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   task automatic send_op(input logic [OPCODE_WIDTH-1:0] op, input logic [PUSH_WIDTH-1:0] value);
      int gap;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [PUSH_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int push_bias;
      int roll;
      logic [OPCODE_WIDTH-1:0] op;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(OP_PEEK, 32'hFFFF_FFFF);
      send_op(OP_POP_BACK, 32'h1234_5678);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_PUSH_BACK, '0);
      send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      for (int i = 0; i < 14; i++)
         send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, i[1] ? 32'hAAAA_5555 : 32'h5555_AAAA);
      send_op(OP_PUSH_BACK, 32'hDEAD_BEEF);
      send_op(OP_PUSH_FRONT, 32'hCAFE_F00D);
      send_op(OP_SPARE_A, '1);
      send_op(OP_SPARE_B, '0);
      send_op(OP_SPARE_C, 32'h8000_0001);
      send_op(OP_POP_BACK, '0);
      send_op(OP_POP_FRONT, '0);

      push_bias = 50;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % PHASE_OPS == 0) begin
            case ($urandom_range(0, 3))
               0:       push_bias = 85;
               1:       push_bias = 15;
               2:       push_bias = 55;
               default: push_bias = 45;
            endcase
         end
         if (n % 40 == 0) sender_idles = ($urandom_range(0, 2) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 6) op = OPCODE_WIDTH'($urandom_range(OP_PEEK, OP_SPARE_C));
         else if (roll < push_bias)
            op = OPCODE_WIDTH'($urandom_range(OP_PUSH_BACK, OP_PUSH_FRONT));
         else op = OPCODE_WIDTH'($urandom_range(OP_POP_BACK, OP_POP_FRONT));
         send_op(op, pick_value());
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int hold;
      int taken;
      bit rsp_idles;
      taken = 0;
      rsp_idles = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == HOLD_AT) hold = HOLD_CYCLES;
         else hold = rsp_idles ? $urandom_range(0, 9) : 0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 40 == 0) rsp_idles = ($urandom_range(0, 2) != 0);
         @(negedge clock);
      end
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque_top.sv
rtl/cdq_checker.sv
sim/deque_checker.sv
sim/tb_top.sv
